// ----- src/atop_pkg.sv -----
// Package of shared constants, types and the register map of the onset picker.
package atop_pkg;

  localparam int unsigned HistoryDepth = 64;
  localparam int unsigned FluxWidth    = 16;
  localparam int unsigned IndexWidth   = 24;
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 12;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_AVG_LEN    = 3'd0,
    REG_STD_LEN    = 3'd1,
    REG_MEAN_MULT  = 3'd2,
    REG_STD_SCALE  = 3'd3,
    REG_REFRACTORY = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_PRODUCT,
    ST_ROOT,
    ST_DIVIDE,
    ST_FINISH
  } state_e;

endpackage

// ----- src/atop_ram.sv -----
// Generic single-port RAM with registered read.
module atop_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ----- src/atop_serial_mul.sv -----
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module atop_serial_mul #(
  parameter int unsigned AWidth = 40,
  parameter int unsigned BWidth = 40,
  parameter int unsigned PWidth = 80
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [AWidth-1:0] a_i,
  input  logic [BWidth-1:0] b_i,
  output logic              done_o,
  output logic [PWidth-1:0] p_o
);
  localparam int unsigned CntWidth = $clog2(BWidth + 1);

  logic [PWidth-1:0]   acc_q, acc_d, a_q, a_d;
  logic [BWidth-1:0]   b_q, b_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                busy_q, busy_d;

  always_comb begin
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      acc_d  = '0;
      a_d    = PWidth'(a_i);
      b_d    = b_i;
      cnt_d  = CntWidth'(BWidth);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_d = acc_q + a_q;
      end
      a_d   = a_q << 1;
      b_d   = b_q >> 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntWidth'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign done_o = busy_q && (cnt_q == CntWidth'(1));
  assign p_o    = acc_d;
endmodule

// ----- src/atop_serial_div.sv -----
// Restoring divider and square root, one quotient or root bit per cycle.
module atop_serial_div #(
  parameter int unsigned NWidth = 80,
  parameter int unsigned DWidth = 20
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              sqrt_i,
  input  logic [NWidth-1:0] num_i,
  input  logic [DWidth-1:0] den_i,
  output logic              done_o,
  output logic [NWidth-1:0] q_o
);
  localparam int unsigned CntWidth = $clog2(NWidth + 1);
  localparam int unsigned RWidth   = NWidth + 2;

  logic [NWidth-1:0]   num_q, num_d, q_q, q_d;
  logic [RWidth-1:0]   rem_q, rem_d, rtry;
  logic [DWidth-1:0]   den_q, den_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                busy_q, busy_d, sqrt_q, sqrt_d;
  logic [RWidth-1:0]   trial;

  always_comb begin
    num_d  = num_q;
    q_d    = q_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    sqrt_d = sqrt_q;
    rtry   = '0;
    trial  = '0;
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      q_d    = '0;
      rem_d  = '0;
      sqrt_d = sqrt_i;
      cnt_d  = sqrt_i ? CntWidth'(NWidth / 2) : CntWidth'(NWidth);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (sqrt_q) begin
        // shift in two radicand bits; trial is 4*root+1
        rtry  = {rem_q[RWidth-3:0], num_q[NWidth-1 -: 2]};
        trial = {q_q[NWidth-1:0], 2'b01};
        num_d = num_q << 2;
      end else begin
        rtry  = {rem_q[RWidth-2:0], num_q[NWidth-1]};
        trial = RWidth'(den_q);
        num_d = num_q << 1;
      end
      if (rtry >= trial) begin
        rem_d = rtry - trial;
        q_d   = {q_q[NWidth-2:0], 1'b1};
      end else begin
        rem_d = rtry;
        q_d   = {q_q[NWidth-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntWidth'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      sqrt_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      sqrt_q <= sqrt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    q_q   <= q_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = busy_q && (cnt_q == CntWidth'(1));
  assign q_o    = q_d;
endmodule

// ----- src/adaptive_threshold_onset_picker.sv -----
// Top level of the adaptive-threshold onset picker.
//
// Usage: one spectral-flux value (unsigned Q8.8) per request on the input
// channel (flux_valid_i / flux_stall_o). Each request yields exactly one result
// on the output channel (res_valid_o / res_stall_i): threshold, pruned flux,
// and an onset flag with the index of the previous frame.
// Sequence: the history window is read one entry a cycle from the ring RAM;
// then shared bit-serial units run in turn: three products, a division, a
// square root, a product and a division; the finish state writes the ring.
// Warm-up frames skip the arithmetic. One request is in flight at a time: a
// new request is accepted only once the block is back in idle.
// Configuration: write cfg_idx_i / cfg_data_i with cfg_valid_i and cfg_ready_o,
// only while idle. Unknown indexes are ignored.
// Reset: history reads as zero (a fill count covers the slots never written),
// frame index, refractory count and previous pruned value clear, registers
// return to 6, 30, 333, 179, 6.
// Stall: the result waits in its output register; the next request is taken
// as soon as the result is taken or at the same edge.
module adaptive_threshold_onset_picker #(
  parameter int unsigned HISTORY_DEPTH = atop_pkg::HistoryDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        flux_valid_i,
  output logic        flux_stall_o,
  input  logic [15:0] flux_i,
  output logic        res_valid_o,
  input  logic        res_stall_i,
  output logic [15:0] threshold_o,
  output logic [15:0] pruned_o,
  output logic        onset_o,
  output logic [23:0] onset_frame_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_idx_i,
  input  logic [11:0] cfg_data_i
);
  localparam int unsigned PtrW  = $clog2(HISTORY_DEPTH);
  localparam int unsigned LenW  = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned MulW  = 80;
  localparam int unsigned DivDW = LenW + 8;
  // std_len is 7 bits, so a window never holds more than 127 entries
  localparam int unsigned SumW  = 16 + 7;
  localparam int unsigned SqW   = 32 + 7;

  // configuration
  logic [6:0]  avg_len_q, std_len_q;
  logic [11:0] mean_mult_q, std_scale_q;
  logic [7:0]  refr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_len_q   <= 7'd6;
      std_len_q   <= 7'd30;
      mean_mult_q <= 12'd333;
      std_scale_q <= 12'd179;
      refr_q      <= 8'd6;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_i)
        atop_pkg::REG_AVG_LEN:    avg_len_q   <= cfg_data_i[6:0];
        atop_pkg::REG_STD_LEN:    std_len_q   <= cfg_data_i[6:0];
        atop_pkg::REG_MEAN_MULT:  mean_mult_q <= cfg_data_i;
        atop_pkg::REG_STD_SCALE:  std_scale_q <= cfg_data_i;
        atop_pkg::REG_REFRACTORY: refr_q      <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end
  assign cfg_ready_o = 1'b1;

  // clamped lengths
  logic [LenW-1:0] n_len, m_len;
  always_comb begin
    if (std_len_q == 7'd0) begin
      n_len = LenW'(1);
    end else if (32'(std_len_q) > HISTORY_DEPTH) begin
      n_len = LenW'(HISTORY_DEPTH);
    end else begin
      n_len = LenW'(std_len_q);
    end
    if (avg_len_q == 7'd0) begin
      m_len = LenW'(1);
    end else if (32'(avg_len_q) > 32'(n_len)) begin
      m_len = n_len;
    end else begin
      m_len = LenW'(avg_len_q);
    end
  end

  // state
  atop_pkg::state_e state_q, state_d;
  logic [PtrW-1:0]  ptr_q;
  logic [LenW-1:0]  fill_q;
  logic [23:0]      frame_q;
  logic [15:0]      prev_pruned_q;
  logic [7:0]       skip_q;
  logic [15:0]      flux_q;
  logic [LenW:0]    k_q;
  logic [2:0]       step_q;
  logic [SumW-1:0]  sm_q, s_q;
  logic [SqW-1:0]   sq_q;
  logic [MulW-1:0]  t0_q, t1_q;
  logic             res_valid_q;
  logic [15:0]      thr_q, pr_q;
  logic             on_q;
  logic [23:0]      onf_q;

  // ring RAM: read back k entries, write at the end
  logic            ram_we;
  logic [PtrW-1:0] ram_addr;
  logic [15:0]     ram_rdata;

  atop_ram #(.Width(16), .Depth(HISTORY_DEPTH)) u_ring (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(flux_q), .rdata_o(ram_rdata)
  );

  // shared serial units
  logic            mul_start, mul_done;
  logic [39:0]     mul_a, mul_b;
  logic [MulW-1:0] mul_p;
  atop_serial_mul #(.AWidth(40), .BWidth(40), .PWidth(MulW)) u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .p_o(mul_p)
  );

  logic             div_start, div_sqrt, div_done;
  logic [MulW-1:0]  div_num, div_q;
  logic [DivDW-1:0] div_den;
  atop_serial_div #(.NWidth(MulW), .DWidth(DivDW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .sqrt_i(div_sqrt), .num_i(div_num),
    .den_i(div_den), .done_o(div_done), .q_o(div_q)
  );

  logic accept, take_out;
  assign take_out     = res_valid_q && !res_stall_i;
  assign flux_stall_o = (state_q != atop_pkg::ST_IDLE) || (res_valid_q && res_stall_i);
  assign accept       = flux_valid_i && !flux_stall_o;

  // the k-th back entry is valid when it was written since reset
  logic [LenW:0] k_rd;
  logic          rd_valid;
  assign ram_addr = (state_q == atop_pkg::ST_ACCUM) ?
                    PtrW'(ptr_q - PtrW'(k_q[LenW-1:0])) : ptr_q;
  assign ram_we   = (state_q == atop_pkg::ST_FINISH);
  logic [15:0] v;
  logic        rdv_q;
  logic [LenW:0] kr_q;

  always_ff @(posedge clk_i) begin
    kr_q  <= k_q;
    rdv_q <= (state_q == atop_pkg::ST_ACCUM) && (k_q >= (LenW+1)'(1)) &&
             (k_q <= (LenW+1)'(n_len)) && ((LenW+1)'(fill_q) >= k_q);
  end
  assign k_rd     = kr_q;
  assign rd_valid = rdv_q;
  assign v        = rd_valid ? ram_rdata : 16'd0;

  // threshold pieces
  logic warm;
  assign warm = (frame_q < 24'(n_len));
  logic [MulW-1:0] thr_sum;
  logic [15:0]     thr_fin, pr_fin;
  assign thr_sum = t0_q + div_q;
  assign thr_fin = warm ? 16'hFFFF : ((thr_sum > MulW'(16'hFFFF)) ? 16'hFFFF : thr_sum[15:0]);
  assign pr_fin  = (flux_q > thr_fin) ? flux_q - thr_fin : 16'd0;

  always_comb begin
    state_d   = state_q;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_sqrt  = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state_q)
      atop_pkg::ST_IDLE: begin
        if (accept) state_d = atop_pkg::ST_ACCUM;
      end
      atop_pkg::ST_ACCUM: begin
        // k_q runs 1..n+1; the read of entry k lands in the next cycle
        if (k_q == (LenW+1)'(n_len) + (LenW+1)'(1)) begin
          state_d = warm ? atop_pkg::ST_FINISH : atop_pkg::ST_PRODUCT;
        end
      end
      atop_pkg::ST_PRODUCT: begin
        // step 0: n*Q, 1: S*S, 2: Sm*mult
        if (step_q[0] == 1'b0 && step_q[1] == 1'b0 && !mul_done && t1_q == '0 &&
            k_q != '0) begin
          mul_start = 1'b1;
        end
        unique case (step_q)
          3'd0: begin mul_a = 40'(sq_q); mul_b = 40'(n_len); end
          3'd1: begin mul_a = 40'(s_q);  mul_b = 40'(s_q);   end
          default: begin mul_a = 40'(sm_q); mul_b = 40'(mean_mult_q); end
        endcase
        if (k_q != '0) mul_start = 1'b1;
        if (mul_done && step_q == 3'd2) state_d = atop_pkg::ST_DIVIDE;
      end
      atop_pkg::ST_DIVIDE: begin
        // step 3: Sm*mult/(m*256), 4: sqrt(D), 5: root*scale, 6: /(n*256)
        // t1 holds D across the mean product and division
        div_num = (step_q == 3'd3) ? t0_q : t1_q;
        div_den = (step_q == 3'd3) ? DivDW'({m_len, 8'd0}) : DivDW'({n_len, 8'd0});
        div_sqrt = (step_q == 3'd4);
        mul_a   = 40'(t1_q);
        mul_b   = 40'(std_scale_q);
        if (k_q != '0) begin
          if (step_q == 3'd5) mul_start = 1'b1;
          else div_start = 1'b1;
        end
        if (div_done && step_q == 3'd6) state_d = atop_pkg::ST_FINISH;
      end
      atop_pkg::ST_FINISH: state_d = atop_pkg::ST_IDLE;
      default: state_d = atop_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= atop_pkg::ST_IDLE;
      ptr_q         <= '0;
      fill_q        <= '0;
      frame_q       <= '0;
      prev_pruned_q <= '0;
      skip_q        <= '0;
      k_q           <= '0;
      step_q        <= '0;
      res_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == atop_pkg::ST_FINISH) begin
        res_valid_q <= 1'b1;
      end else if (take_out) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        atop_pkg::ST_IDLE: begin
          k_q <= accept ? (LenW+1)'(1) : '0;
        end
        atop_pkg::ST_ACCUM: begin
          if (state_d != atop_pkg::ST_ACCUM) begin
            k_q    <= (LenW+1)'(1);
            step_q <= '0;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        atop_pkg::ST_PRODUCT, atop_pkg::ST_DIVIDE: begin
          // k_q flags a pending start of the next unit
          if (mul_done || div_done) begin
            step_q <= step_q + 1'b1;
            k_q    <= (LenW+1)'(1);
          end else begin
            k_q <= '0;
          end
        end
        atop_pkg::ST_FINISH: begin
          ptr_q   <= ptr_q + 1'b1;
          if (32'(fill_q) < HISTORY_DEPTH) fill_q <= fill_q + 1'b1;
          frame_q <= frame_q + 1'b1;
          prev_pruned_q <= pr_fin;
          if (skip_q != 8'd0) begin
            skip_q <= skip_q - 1'b1;
          end else if (prev_pruned_q > pr_fin) begin
            skip_q <= (refr_q == 8'd0) ? 8'd0 : refr_q - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) flux_q <= flux_i;
    if (state_q == atop_pkg::ST_IDLE) begin
      sm_q <= '0;
      s_q  <= '0;
      sq_q <= '0;
    end else if (state_q == atop_pkg::ST_ACCUM && rd_valid) begin
      // one history entry per cycle; the square is only 16x16
      s_q  <= s_q + SumW'(v);
      sq_q <= sq_q + SqW'(32'(v) * 32'(v));
      if (k_rd <= (LenW+1)'(m_len)) sm_q <= sm_q + SumW'(v);
    end
    if (state_q == atop_pkg::ST_ACCUM) t1_q <= '0;
    if (mul_done) begin
      unique case (step_q)
        3'd0:    t1_q <= mul_p;
        3'd1:    t1_q <= (t1_q > mul_p) ? t1_q - mul_p : '0;
        3'd2:    begin t0_q <= mul_p; end
        default: t1_q <= mul_p;
      endcase
    end
    if (div_done) begin
      unique case (step_q)
        3'd3:    begin t0_q <= div_q; end
        3'd4:    t1_q <= div_q;
        default: ;
      endcase
    end
    if (state_q == atop_pkg::ST_FINISH) begin
      thr_q <= thr_fin;
      pr_q  <= pr_fin;
      on_q  <= (skip_q == 8'd0) && (prev_pruned_q > pr_fin);
      onf_q <= ((skip_q == 8'd0) && (prev_pruned_q > pr_fin)) ? frame_q - 1'b1 : 24'd0;
    end
  end

  assign res_valid_o   = res_valid_q;
  assign threshold_o   = thr_q;
  assign pruned_o      = pr_q;
  assign onset_o       = on_q;
  assign onset_frame_o = onf_q;
endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the adaptive-threshold onset picker.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned RingDepth  = 64;
  localparam int unsigned WatchLimit = 20000;
  localparam int unsigned HoldCycles = 1500;
  localparam int unsigned DrainWait  = 600;
  localparam logic [2:0]  UnusedIdx  = 3'd7;

  typedef struct packed {
    logic [15:0] threshold;
    logic [15:0] pruned;
    logic        onset;
    logic [23:0] onset_frame;
  } frame_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        flux_valid_i = 1'b0;
  logic        flux_stall_o;
  logic [15:0] flux_i = '0;
  logic        res_valid_o;
  logic        res_stall_i = 1'b0;
  logic [15:0] threshold_o;
  logic [15:0] pruned_o;
  logic        onset_o;
  logic [23:0] onset_frame_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_idx_i = '0;
  logic [11:0] cfg_data_i = '0;

  adaptive_threshold_onset_picker dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state: history ring, frame bookkeeping and register copies.
  logic [15:0] hist_ring [RingDepth];
  logic [5:0]  hist_ptr;
  logic [23:0] frame_cnt;
  logic [15:0] last_pruned;
  logic [7:0]  skip_left;
  logic [6:0]  avg_len_q, std_len_q;
  logic [11:0] mean_mult_q, std_scale_q;
  logic [7:0]  refractory_q;

  frame_result_t expected_results[$];
  int mismatches = 0;
  int onsets_seen = 0;
  int results_seen = 0;
  bit calm = 1'b0;   // no idling on either side while set
  int hold_req = 0, hold_done = 0;

  function automatic logic [63:0] floor_sqrt(logic [63:0] d);
    logic [63:0] root, trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= d) root = trial;
    end
    return root;
  endfunction

  // Threshold, pruned flux and onset decision for one frame; advance the state.
  function automatic frame_result_t predict_frame(logic [15:0] flux);
    frame_result_t r;
    int unsigned n, m, refr;
    logic [63:0] s_mean, s_all, s_sq, v, nq, ss, d, thr, mean_term, dev_term;
    n = std_len_q;
    if (n < 1) n = 1;
    if (n > RingDepth) n = RingDepth;
    m = avg_len_q;
    if (m < 1) m = 1;
    if (m > n) m = n;
    refr = (refractory_q == 0) ? 1 : refractory_q;
    s_mean = 0; s_all = 0; s_sq = 0;
    for (int k = 1; k <= n; k++) begin
      v = hist_ring[6'(hist_ptr - 6'(k))];
      s_all += v;
      s_sq += v * v;
      if (k <= m) s_mean += v;
    end
    if (frame_cnt < n) begin
      thr = 64'hFFFF;
    end else begin
      nq = n * s_sq;
      ss = s_all * s_all;
      d = (nq > ss) ? nq - ss : 0;
      mean_term = (s_mean * mean_mult_q) / (m * 256);
      dev_term = (floor_sqrt(d) * std_scale_q) / (n * 256);
      thr = mean_term + dev_term;
      if (thr > 64'hFFFF) thr = 64'hFFFF;
    end
    r.threshold = thr[15:0];
    r.pruned = (flux > thr) ? flux - thr[15:0] : 16'd0;
    r.onset = 1'b0;
    r.onset_frame = '0;
    if (skip_left > 0) begin
      skip_left--;
    end else if (last_pruned > r.pruned) begin
      r.onset = 1'b1;
      r.onset_frame = frame_cnt - 24'd1;
      skip_left = 8'(refr - 1);
    end
    hist_ring[hist_ptr] = flux;
    hist_ptr++;
    frame_cnt++;
    last_pruned = r.pruned;
    return r;
  endfunction

  // Send one flux request; leave valid high so the next one can follow at once.
  task automatic send_flux(logic [15:0] flux);
    int gap;
    frame_result_t exp_r;
    gap = (!calm && $urandom_range(99) < 30) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      flux_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    flux_valid_i <= 1'b1;
    flux_i <= flux;
    do @(posedge clk_i); while (flux_stall_o);
    exp_r = predict_frame(flux);
    expected_results.insert(expected_results.size(), exp_r);
  endtask

  task automatic drop_flux();
    flux_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Register write; the block must be idle with every result drained.
  task automatic write_reg(logic [2:0] idx, logic [11:0] data);
    wait (expected_results.size() == 0);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      atop_pkg::REG_AVG_LEN:    avg_len_q = data[6:0];
      atop_pkg::REG_STD_LEN:    std_len_q = data[6:0];
      atop_pkg::REG_MEAN_MULT:  mean_mult_q = data;
      atop_pkg::REG_STD_SCALE:  std_scale_q = data;
      atop_pkg::REG_REFRACTORY: refractory_q = data[7:0];
      default: ;
    endcase
  endtask

  task automatic setup(int a, int s, int mm, int sc, int rf);
    drop_flux();
    write_reg(atop_pkg::REG_AVG_LEN, 12'(a));
    write_reg(atop_pkg::REG_STD_LEN, 12'(s));
    write_reg(atop_pkg::REG_MEAN_MULT, 12'(mm));
    write_reg(atop_pkg::REG_STD_SCALE, 12'(sc));
    write_reg(atop_pkg::REG_REFRACTORY, 12'(rf));
    write_reg(UnusedIdx, 12'($urandom_range(4095)));
  endtask

  // Mostly quiet background with sparse peaks, some noise and full-scale values.
  function automatic logic [15:0] random_flux();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) return 16'($urandom_range(0, 3000));
    if (pick < 75) return 16'($urandom_range(5000, 65535));
    if (pick < 92) return 16'($urandom);
    return (pick < 96) ? 16'd0 : 16'hFFFF;
  endfunction

  task automatic run_random(int count);
    repeat (count) send_flux(random_flux());
  endtask

  task automatic test_directed();
    // Warm-up with the defaults, then full-scale and zero flux.
    send_flux(16'hFFFF);
    send_flux(16'h0000);
    send_flux(16'h8000);
    // Threshold equals the previous flux: equal flux prunes to zero.
    setup(1, 1, 256, 0, 1);
    send_flux(16'h1234);
    send_flux(16'h1234);
    send_flux(16'hFFFF);
    send_flux(16'hFFFF);
    // Alternately rising and falling pruned values with refractory one: an onset at each fall.
    send_flux(16'h0100);
    send_flux(16'hF000);
    send_flux(16'h0000);
    send_flux(16'hFFFF);
    send_flux(16'h0001);
    // Saturated threshold with the largest factors.
    setup(127, 127, 4095, 4095, 0);
    repeat (4) send_flux(16'hFFFF);
    send_flux(16'h5555);
    send_flux(16'hAAAA);
  endtask

  task automatic test_defaults();
    setup(6, 30, 333, 179, 6);
    run_random(70);
  endtask

  task automatic test_zero_regs();
    setup(0, 0, 0, 0, 0);
    run_random(50);
  endtask

  task automatic test_long_window();
    setup(64, 64, 128, 300, 255);
    run_random(90);
  endtask

  // No idling at all on either side for a whole phase.
  task automatic test_back_to_back();
    setup(3, 8, 512, 256, 2);
    calm = 1'b1;
    run_random(60);
    calm = 1'b0;
  endtask

  // Hold off the result side long enough that the input stalls.
  task automatic test_output_hold();
    setup(1, 1, 256, 0, 1);
    hold_req++;
    run_random(40);
  endtask

  task automatic test_random_regs();
    repeat (5) begin
      setup($urandom_range(127), $urandom_range(127), $urandom_range(4095),
            $urandom_range(4095), $urandom_range(255));
      run_random(40);
    end
  endtask

  // Result side: random stall, optional long hold, check of all result fields.
  int hold_left = 0;
  always @(posedge clk_i) begin
    frame_result_t exp_r;
    if (res_valid_o && !res_stall_i) begin
      results_seen++;
      if (onset_o) onsets_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at %0t", $time);
      end else begin
        exp_r = expected_results.pop_front();
        if (exp_r !== {threshold_o, pruned_o, onset_o, onset_frame_o}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: exp thr %h pr %h on %b fr %h, got %h %h %b %h",
                     $time, exp_r.threshold, exp_r.pruned, exp_r.onset,
                     exp_r.onset_frame, threshold_o, pruned_o, onset_o, onset_frame_o);
        end
      end
    end
    if (hold_done != hold_req) begin
      hold_done = hold_req;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_stall_i <= 1'b1;
    end else begin
      res_stall_i <= !calm && ($urandom_range(99) < 30);
    end
  end

  // Watchdog: too long without any handshake ends the run.
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((flux_valid_i && !flux_stall_o) || (res_valid_o && !res_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles > WatchLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    foreach (hist_ring[i]) hist_ring[i] = '0;
    hist_ptr = '0;
    frame_cnt = '0;
    last_pruned = '0;
    skip_left = '0;
    avg_len_q = 7'd6;
    std_len_q = 7'd30;
    mean_mult_q = 12'd333;
    std_scale_q = 12'd179;
    refractory_q = 8'd6;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_defaults();
    test_zero_regs();
    test_long_window();
    test_back_to_back();
    test_output_hold();
    test_random_regs();
    drop_flux();
    wait (expected_results.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
    $display("Covered %0d frames, %0d onsets, register sets from clamped minimum to maximum.",
             results_seen, onsets_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
